// ===== rtl/accumulator_cpu_execute_unit_core_assert.svh =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit assertion macros
// Shared property forms for the checkers of the execute unit.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH
`define ACCUMULATOR_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ACEU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("execute unit assertion failed");

// Next-cycle implication, checked outside reset.
`define ACEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("execute unit assertion failed");

`endif

// ===== rtl/aceu_pkg.sv =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit package
// Operation codes, write kinds, flag positions and the shared record types.
// ----------------------------------------------------------------------------
package aceu_pkg;

    typedef enum logic [5:0] {
        ACT_LDA = 6'd0,  ACT_LDX = 6'd1,  ACT_LDY = 6'd2,  ACT_STA = 6'd3,
        ACT_STX = 6'd4,  ACT_STY = 6'd5,  ACT_TAX = 6'd6,  ACT_TAY = 6'd7,
        ACT_TXA = 6'd8,  ACT_TYA = 6'd9,  ACT_TSX = 6'd10, ACT_TXS = 6'd11,
        ACT_PHA = 6'd12, ACT_PHP = 6'd13, ACT_PLA = 6'd14, ACT_PLP = 6'd15,
        ACT_AND = 6'd16, ACT_EOR = 6'd17, ACT_ORA = 6'd18, ACT_BIT = 6'd19,
        ACT_ADC = 6'd20, ACT_SBC = 6'd21, ACT_CMP = 6'd22, ACT_CPX = 6'd23,
        ACT_CPY = 6'd24, ACT_INC = 6'd25, ACT_DEC = 6'd26, ACT_INX = 6'd27,
        ACT_INY = 6'd28, ACT_DEX = 6'd29, ACT_DEY = 6'd30, ACT_ASL = 6'd31,
        ACT_LSR = 6'd32, ACT_ROL = 6'd33, ACT_ROR = 6'd34, ACT_CLC = 6'd35,
        ACT_SEC = 6'd36, ACT_CLI = 6'd37, ACT_SEI = 6'd38, ACT_CLV = 6'd39,
        ACT_CLD = 6'd40, ACT_SED = 6'd41, ACT_BPL = 6'd42, ACT_BMI = 6'd43,
        ACT_BVC = 6'd44, ACT_BVS = 6'd45, ACT_BCC = 6'd46, ACT_BCS = 6'd47,
        ACT_BNE = 6'd48, ACT_BEQ = 6'd49, ACT_NOP = 6'd50
    } action_t;

    typedef enum logic [1:0] {
        WK_NONE = 2'd0,
        WK_ADDR = 2'd1,
        WK_PUSH = 2'd2
    } wkind_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] STATUS_RESET = 8'h24;
    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] MASK_BU      = 8'h30;
    localparam logic [7:0] MASK_U       = 8'h20;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } regs_t;

    typedef struct packed {
        logic [5:0] action;
        logic [7:0] operand;
        logic       on_acc;
    } item_t;

    typedef struct packed {
        wkind_t     write_kind;
        logic [7:0] write_data;
        logic       taken;
        regs_t      regs;
    } result_t;

endpackage

// ===== rtl/aceu_if.sv =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit channels
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface aceu_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] action;
    logic [7:0] operand;
    logic       on_accumulator;

    modport source (output valid, output action, output operand, output on_accumulator,
                    input ready);
    modport sink   (input valid, input action, input operand, input on_accumulator,
                    output ready);
endinterface

interface aceu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] write_kind;
    logic [7:0] write_data;
    logic       branch_taken;
    logic [7:0] status_out;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;

    modport source (output valid, output write_kind, output write_data,
                    output branch_taken, output status_out, output acc_out,
                    output x_out, output y_out, output sp_out, input ready);
    modport sink   (input valid, input write_kind, input write_data,
                    input branch_taken, input status_out, input acc_out,
                    input x_out, input y_out, input sp_out, output ready);
endinterface

// ===== rtl/aceu_in_stage.sv =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit input stage
// Registers one operation beat and holds it until the execute logic takes it.
// ----------------------------------------------------------------------------
module aceu_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    aceu_in_if.sink         cmd,
    input  logic            take,
    output logic            item_valid,
    output aceu_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    aceu_pkg::item_t item_reg;
    logic            accept;

    assign cmd.ready = !valid_reg || take;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action  <= cmd.action;
            item_reg.operand <= cmd.operand;
            item_reg.on_acc  <= cmd.on_accumulator;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/aceu_alu.sv =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit ALU
// Computes the register, flag, write and branch outcome of one operation.
// ----------------------------------------------------------------------------
module aceu_alu (
    input  aceu_pkg::regs_t   cur,
    input  aceu_pkg::item_t   item,
    output aceu_pkg::result_t res
);

    function automatic logic [7:0] with_nz(input logic [7:0] flags, input logic [7:0] v);
        logic [7:0] f;
        f                  = flags;
        f[aceu_pkg::FLAG_Z] = (v == 8'h00);
        f[aceu_pkg::FLAG_N] = v[7];
        return f;
    endfunction

    aceu_pkg::action_t act;
    aceu_pkg::regs_t   nxt;
    logic [7:0]        m;
    logic [7:0]        m_add;
    logic [8:0]        sum;
    logic              carry;
    logic [7:0]        src;
    logic [7:0]        shifted;
    logic [7:0]        cmp_reg;
    logic [8:0]        diff;

    assign act   = aceu_pkg::action_t'(item.action);
    assign m     = item.operand;
    assign carry = cur.p[aceu_pkg::FLAG_C];
    assign m_add = (act == aceu_pkg::ACT_SBC) ? ~m : m;
    assign sum   = {1'b0, cur.a} + {1'b0, m_add} + {8'h00, carry};
    assign src   = item.on_acc ? cur.a : m;
    assign diff  = {1'b0, cmp_reg} - {1'b0, m};

    always_comb
    begin
        unique case (act)
            aceu_pkg::ACT_CPX: cmp_reg = cur.x;
            aceu_pkg::ACT_CPY: cmp_reg = cur.y;
            default:           cmp_reg = cur.a;
        endcase
    end

    always_comb
    begin
        unique case (act)
            aceu_pkg::ACT_ASL: shifted = {src[6:0], 1'b0};
            aceu_pkg::ACT_LSR: shifted = {1'b0, src[7:1]};
            aceu_pkg::ACT_ROL: shifted = {src[6:0], carry};
            default:           shifted = {carry, src[7:1]};
        endcase
    end

    always_comb
    begin
        nxt            = cur;
        res.write_kind = aceu_pkg::WK_NONE;
        res.write_data = 8'h00;
        res.taken      = 1'b0;
        unique case (act)
            aceu_pkg::ACT_LDA:
            begin
                nxt.a = m;
                nxt.p = with_nz(cur.p, m);
            end
            aceu_pkg::ACT_LDX:
            begin
                nxt.x = m;
                nxt.p = with_nz(cur.p, m);
            end
            aceu_pkg::ACT_LDY:
            begin
                nxt.y = m;
                nxt.p = with_nz(cur.p, m);
            end
            aceu_pkg::ACT_STA:
            begin
                res.write_kind = aceu_pkg::WK_ADDR;
                res.write_data = cur.a;
            end
            aceu_pkg::ACT_STX:
            begin
                res.write_kind = aceu_pkg::WK_ADDR;
                res.write_data = cur.x;
            end
            aceu_pkg::ACT_STY:
            begin
                res.write_kind = aceu_pkg::WK_ADDR;
                res.write_data = cur.y;
            end
            aceu_pkg::ACT_TAX:
            begin
                nxt.x = cur.a;
                nxt.p = with_nz(cur.p, cur.a);
            end
            aceu_pkg::ACT_TAY:
            begin
                nxt.y = cur.a;
                nxt.p = with_nz(cur.p, cur.a);
            end
            aceu_pkg::ACT_TXA:
            begin
                nxt.a = cur.x;
                nxt.p = with_nz(cur.p, cur.x);
            end
            aceu_pkg::ACT_TYA:
            begin
                nxt.a = cur.y;
                nxt.p = with_nz(cur.p, cur.y);
            end
            aceu_pkg::ACT_TSX:
            begin
                nxt.x = cur.sp;
                nxt.p = with_nz(cur.p, cur.sp);
            end
            aceu_pkg::ACT_TXS:
            begin
                nxt.sp = cur.x;
            end
            aceu_pkg::ACT_PHA:
            begin
                res.write_kind = aceu_pkg::WK_PUSH;
                res.write_data = cur.a;
                nxt.sp         = cur.sp - 8'd1;
            end
            aceu_pkg::ACT_PHP:
            begin
                res.write_kind = aceu_pkg::WK_PUSH;
                res.write_data = cur.p | aceu_pkg::MASK_BU;
                nxt.sp         = cur.sp - 8'd1;
            end
            aceu_pkg::ACT_PLA:
            begin
                nxt.sp = cur.sp + 8'd1;
                nxt.a  = m;
                nxt.p  = with_nz(cur.p, m);
            end
            aceu_pkg::ACT_PLP:
            begin
                nxt.sp = cur.sp + 8'd1;
                nxt.p  = (m & ~aceu_pkg::MASK_BU) | aceu_pkg::MASK_U;
            end
            aceu_pkg::ACT_AND:
            begin
                nxt.a = cur.a & m;
                nxt.p = with_nz(cur.p, cur.a & m);
            end
            aceu_pkg::ACT_EOR:
            begin
                nxt.a = cur.a ^ m;
                nxt.p = with_nz(cur.p, cur.a ^ m);
            end
            aceu_pkg::ACT_ORA:
            begin
                nxt.a = cur.a | m;
                nxt.p = with_nz(cur.p, cur.a | m);
            end
            aceu_pkg::ACT_BIT:
            begin
                nxt.p[aceu_pkg::FLAG_Z] = ((cur.a & m) == 8'h00);
                nxt.p[aceu_pkg::FLAG_V] = m[6];
                nxt.p[aceu_pkg::FLAG_N] = m[7];
            end
            aceu_pkg::ACT_ADC, aceu_pkg::ACT_SBC:
            begin
                nxt.a                   = sum[7:0];
                nxt.p                   = with_nz(cur.p, sum[7:0]);
                nxt.p[aceu_pkg::FLAG_C] = sum[8];
                nxt.p[aceu_pkg::FLAG_V] = ~(cur.a[7] ^ m_add[7]) & (cur.a[7] ^ sum[7]);
            end
            aceu_pkg::ACT_CMP, aceu_pkg::ACT_CPX, aceu_pkg::ACT_CPY:
            begin
                nxt.p                   = with_nz(cur.p, diff[7:0]);
                nxt.p[aceu_pkg::FLAG_C] = ~diff[8];
            end
            aceu_pkg::ACT_INC:
            begin
                res.write_kind = aceu_pkg::WK_ADDR;
                res.write_data = m + 8'd1;
                nxt.p          = with_nz(cur.p, m + 8'd1);
            end
            aceu_pkg::ACT_DEC:
            begin
                res.write_kind = aceu_pkg::WK_ADDR;
                res.write_data = m - 8'd1;
                nxt.p          = with_nz(cur.p, m - 8'd1);
            end
            aceu_pkg::ACT_INX:
            begin
                nxt.x = cur.x + 8'd1;
                nxt.p = with_nz(cur.p, cur.x + 8'd1);
            end
            aceu_pkg::ACT_INY:
            begin
                nxt.y = cur.y + 8'd1;
                nxt.p = with_nz(cur.p, cur.y + 8'd1);
            end
            aceu_pkg::ACT_DEX:
            begin
                nxt.x = cur.x - 8'd1;
                nxt.p = with_nz(cur.p, cur.x - 8'd1);
            end
            aceu_pkg::ACT_DEY:
            begin
                nxt.y = cur.y - 8'd1;
                nxt.p = with_nz(cur.p, cur.y - 8'd1);
            end
            aceu_pkg::ACT_ASL, aceu_pkg::ACT_LSR, aceu_pkg::ACT_ROL, aceu_pkg::ACT_ROR:
            begin
                nxt.p = with_nz(cur.p, shifted);
                nxt.p[aceu_pkg::FLAG_C] =
                    (act == aceu_pkg::ACT_ASL || act == aceu_pkg::ACT_ROL) ? src[7] : src[0];
                if (item.on_acc)
                begin
                    nxt.a = shifted;
                end
                else
                begin
                    res.write_kind = aceu_pkg::WK_ADDR;
                    res.write_data = shifted;
                end
            end
            aceu_pkg::ACT_CLC: nxt.p[aceu_pkg::FLAG_C] = 1'b0;
            aceu_pkg::ACT_SEC: nxt.p[aceu_pkg::FLAG_C] = 1'b1;
            aceu_pkg::ACT_CLI: nxt.p[aceu_pkg::FLAG_I] = 1'b0;
            aceu_pkg::ACT_SEI: nxt.p[aceu_pkg::FLAG_I] = 1'b1;
            aceu_pkg::ACT_CLV: nxt.p[aceu_pkg::FLAG_V] = 1'b0;
            aceu_pkg::ACT_CLD: nxt.p[aceu_pkg::FLAG_D] = 1'b0;
            aceu_pkg::ACT_SED: nxt.p[aceu_pkg::FLAG_D] = 1'b1;
            aceu_pkg::ACT_BPL: res.taken = ~cur.p[aceu_pkg::FLAG_N];
            aceu_pkg::ACT_BMI: res.taken = cur.p[aceu_pkg::FLAG_N];
            aceu_pkg::ACT_BVC: res.taken = ~cur.p[aceu_pkg::FLAG_V];
            aceu_pkg::ACT_BVS: res.taken = cur.p[aceu_pkg::FLAG_V];
            aceu_pkg::ACT_BCC: res.taken = ~cur.p[aceu_pkg::FLAG_C];
            aceu_pkg::ACT_BCS: res.taken = cur.p[aceu_pkg::FLAG_C];
            aceu_pkg::ACT_BNE: res.taken = ~cur.p[aceu_pkg::FLAG_Z];
            aceu_pkg::ACT_BEQ: res.taken = cur.p[aceu_pkg::FLAG_Z];
            default:
            begin
            end
        endcase
        res.regs = nxt;
    end

endmodule

// ===== rtl/accumulator_cpu_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit
// Executes one operation beat per cycle unless stalled, on A, X, Y, SP, status.
// ----------------------------------------------------------------------------
// A beat accepted on cmd passes the input register, then the result register
// that drives res; the unit sustains one beat per cycle unless res stalls:
// the input register feeds combinational execute logic that updates the
// architectural registers and the result register at the same edge, so each
// operation sees the registers left by the one before it. A stalled result
// holds in the result register while the next beat waits in the input register.
module accumulator_cpu_execute_unit_core (
    input  logic      clk,
    input  logic      rst_n,
    aceu_in_if.sink   cmd,
    aceu_out_if.source res
);

    logic              item_valid;
    aceu_pkg::item_t   item;
    logic              take;
    aceu_pkg::regs_t   regs_reg;
    aceu_pkg::result_t alu_res;
    aceu_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    aceu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    aceu_alu u_alu (
        .cur  (regs_reg),
        .item (item),
        .res  (alu_res)
    );

    assign take = item_valid && (!out_valid_reg || res.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.a    <= 8'h00;
            regs_reg.x    <= 8'h00;
            regs_reg.y    <= 8'h00;
            regs_reg.sp   <= aceu_pkg::SP_RESET;
            regs_reg.p    <= aceu_pkg::STATUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                regs_reg <= alu_res.regs;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= alu_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.write_kind   = out_reg.write_kind;
    assign res.write_data   = out_reg.write_data;
    assign res.branch_taken = out_reg.taken;
    assign res.status_out   = out_reg.regs.p;
    assign res.acc_out      = out_reg.regs.a;
    assign res.x_out        = out_reg.regs.x;
    assign res.y_out        = out_reg.regs.y;
    assign res.sp_out       = out_reg.regs.sp;

endmodule

// ===== rtl/aceu_checker.sv =====
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_execute_unit_core_assert.svh"

module aceu_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] write_kind,
    input logic [7:0] write_data,
    input logic       branch_taken,
    input logic [7:0] status_out
);

    logic        fixed_bits_ok;
    logic        no_write;
    logic        kind_data_ok;
    logic        res_stall;
    logic [18:0] res_beat;

    assign fixed_bits_ok = status_out[aceu_pkg::FLAG_U] && !status_out[aceu_pkg::FLAG_B];
    assign no_write      = (write_kind == aceu_pkg::WK_NONE);
    assign kind_data_ok  = (no_write && write_data == 8'h00) ||
                           write_kind == aceu_pkg::WK_ADDR ||
                           write_kind == aceu_pkg::WK_PUSH;
    assign res_stall     = res_valid && !res_ready;
    assign res_beat      = {write_kind, write_data, branch_taken, status_out};

    // Status bit 5 always reads one and B always reads zero.
    `ACEU_ASSERT_IMP(a_status_fixed_bits, clk, rst_n, res_valid, fixed_bits_ok)

    // A branch never requests a write.
    `ACEU_ASSERT_IMP(a_branch_no_write, clk, rst_n, res_valid && branch_taken, no_write)

    // Write data is zero when no write is requested, and the unused kind never shows.
    `ACEU_ASSERT_IMP(a_write_kind_data, clk, rst_n, res_valid, kind_data_ok)

    // A stalled result beat holds.
    `ACEU_ASSERT_NEXT(a_stall_holds, clk, rst_n, res_stall, res_valid && $stable(res_beat))

endmodule

bind accumulator_cpu_execute_unit_core aceu_port_checker u_aceu_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .write_kind   (res.write_kind),
    .write_data   (res.write_data),
    .branch_taken (res.branch_taken),
    .status_out   (res.status_out)
);
